/* src/ptt_pkg.sv */
`default_nettype none
package ptt_pkg;
   localparam int unsigned NumSlotsDefault = 16;
   localparam int unsigned SlotOutW = 4;
   localparam int unsigned ResultLimit = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RK_STARTED = 2'd0,
      RK_FULL    = 2'd1,
      RK_ANSWER  = 2'd2,
      RK_FIRED   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [63:0] deadline;
      logic [31:0] period;
      logic        repeat_mode;
      logic [31:0] argument;
   } slot_entry_type;
endpackage
`default_nettype wire

/* src/periodic_timer_table.sv */
`default_nettype none
// channel   direction  fields
// req_      in         tdata {slot_number, user_argument, repeat_mode, period_ticks, operation}
// rsp_      out        tdata {fired_argument, answer_flag, result_slot, result_kind}, tlast
// Start, stop and query pass S_START or S_ANS, then S_OUT (held by a result stall), before ready.
// A tick scans the slot memory in S_SCAN_RD and S_SCAN (one read port, one slot a cycle).
// Each firing slot adds a fetch, an update, the output of the previous firing and the next
// search; the first has no output, and the final result is output after the last search.
// Reset clears time and the in-use bits; slot data memory is not cleared.
// A stalled result is held in the output register; no new request is taken meanwhile.
module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [33:2] period_ticks, [34] repeat_mode,
   // [66:35] user_argument, [70:67] slot_number, [71] zero
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] result_kind, [5:2] result_slot, [6] answer_flag, [38:7] fired_argument,
   // [39] zero
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
   localparam int unsigned NW = $clog2(ResultLimit + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_ANS, S_SCAN_RD, S_SCAN, S_FIRE_RD, S_FIRE, S_FIRE_WR, S_OUT
   } state_type;

   state_type        state_ff;
   logic [63:0]      time_ff;
   logic [NUM_SLOTS-1:0] use_ff, done_ff;
   op_type           op_ff;
   logic [31:0]      period_ff, arg_ff;
   logic             rep_ff;
   logic [3:0]       sn_ff;
   logic [CW-1:0]    idx_ff;
   logic             found_ff;
   logic [AW-1:0]    best_ff;
   logic [63:0]      bestdl_ff;
   logic [NW-1:0]    nfired_ff;
   logic             more_ff;
   logic [AW-1:0]    hold_slot_ff;
   logic [31:0]      hold_arg_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   slot_entry_type   wr_data, rd_data;

   logic [AW-1:0]    free_idx;
   logic             free_any;
   logic [AW-1:0]    scan_addr;
   logic             sn_in;

   assign scan_addr = idx_ff[AW-1:0];
   assign sn_in = ({{(32-4){1'b0}}, sn_ff} < NUM_SLOTS) && use_ff[AW'(sn_ff)];

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_any = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   ptt_slot_ram #(.NUM_SLOTS(NUM_SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_ff;
      wr_data = rd_data;
      rd_addr = scan_addr;
      if (state_ff == S_START && free_any) begin
         wr_en   = 1'b1;
         wr_addr = free_idx;
         wr_data.deadline    = time_ff + {32'd0, period_ff};
         wr_data.period      = period_ff;
         wr_data.repeat_mode = rep_ff;
         wr_data.argument    = arg_ff;
      end else if (state_ff == S_FIRE_WR) begin
         wr_en = rd_data.repeat_mode && (rd_data.period != 32'd0);
         wr_data.deadline = rd_data.deadline + {32'd0, rd_data.period};
      end
      if (state_ff == S_FIRE_RD || state_ff == S_FIRE || state_ff == S_FIRE_WR) begin
         rd_addr = best_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         time_ff    <= '0;
         use_ff     <= '0;
         rsp_tvalid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= op_type'(req_tdata[1:0]);
                  period_ff <= req_tdata[33:2];
                  rep_ff    <= req_tdata[34];
                  arg_ff    <= req_tdata[66:35];
                  sn_ff     <= req_tdata[70:67];
                  case (op_type'(req_tdata[1:0]))
                     OP_TICK: begin
                        time_ff   <= time_ff + 64'd1;
                        done_ff   <= '0;
                        nfired_ff <= '0;
                        idx_ff    <= '0;
                        found_ff  <= 1'b0;
                        state_ff  <= S_SCAN_RD;
                     end
                     OP_START: state_ff <= S_START;
                     default:  state_ff <= S_ANS;
                  endcase
               end
            end
            S_START: begin
               rsp_tvalid <= 1'b1;
               rsp_tlast  <= 1'b1;
               if (free_any) begin
                  use_ff[free_idx] <= 1'b1;
                  rsp_tdata <= {1'b0, 32'd0, 1'b0, SlotOutW'(free_idx), RK_STARTED};
               end else begin
                  rsp_tdata <= {1'b0, 32'd0, 1'b0, 4'd0, RK_FULL};
               end
               more_ff  <= 1'b0;
               state_ff <= S_OUT;
            end
            S_ANS: begin
               rsp_tvalid <= 1'b1;
               rsp_tlast  <= 1'b1;
               rsp_tdata  <= {1'b0, 32'd0, sn_in, sn_ff, RK_ANSWER};
               if (sn_in && op_ff == OP_STOP) begin
                  use_ff[AW'(sn_ff)] <= 1'b0;
               end
               more_ff  <= 1'b0;
               state_ff <= S_OUT;
            end
            S_SCAN_RD: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // rd_data belongs to slot idx_ff-1
               if (use_ff[AW'(idx_ff - CW'(1))] && !done_ff[AW'(idx_ff - CW'(1))] &&
                   rd_data.deadline <= time_ff &&
                   (!found_ff || rd_data.deadline < bestdl_ff)) begin
                  found_ff  <= 1'b1;
                  best_ff   <= AW'(idx_ff - CW'(1));
                  bestdl_ff <= rd_data.deadline;
               end
               if (idx_ff == CW'(NUM_SLOTS)) begin
                  state_ff <= S_FIRE_RD;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_FIRE_RD: begin
               if (!found_ff) begin
                  if (nfired_ff != '0) begin
                     rsp_tdata  <= {1'b0, hold_arg_ff, 1'b0, SlotOutW'(hold_slot_ff),
                                    RK_FIRED};
                     rsp_tlast  <= 1'b1;
                     rsp_tvalid <= 1'b1;
                     more_ff    <= 1'b0;
                     state_ff   <= S_OUT;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_FIRE;
               end
            end
            S_FIRE: state_ff <= S_FIRE_WR;
            S_FIRE_WR: begin
               done_ff[best_ff] <= 1'b1;
               if (!(rd_data.repeat_mode && rd_data.period != 32'd0)) begin
                  use_ff[best_ff] <= 1'b0;
               end
               // hold this firing until the next search decides tlast
               hold_slot_ff <= best_ff;
               hold_arg_ff  <= rd_data.argument;
               nfired_ff    <= nfired_ff + NW'(1);
               idx_ff       <= '0;
               found_ff     <= 1'b0;
               if (nfired_ff != '0) begin
                  rsp_tdata  <= {1'b0, hold_arg_ff, 1'b0, SlotOutW'(hold_slot_ff),
                                 RK_FIRED};
                  rsp_tlast  <= 1'b0;
                  rsp_tvalid <= 1'b1;
                  more_ff    <= 1'b1;
                  state_ff   <= S_OUT;
               end else if (nfired_ff + NW'(1) == NW'(ResultLimit)) begin
                  state_ff <= S_FIRE_RD;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  if (!more_ff) begin
                     state_ff <= S_IDLE;
                  end else if (nfired_ff == NW'(ResultLimit)) begin
                     state_ff <= S_FIRE_RD;
                  end else begin
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* src/ptt_slot_ram.sv */
`default_nettype none
module ptt_slot_ram
   import ptt_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = NumSlotsDefault,
   localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire slot_entry_type wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   output slot_entry_type      rd_data
);
   slot_entry_type mem [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import ptt_pkg::*;

   localparam int NSLOT = 16;
   localparam int TIMEOUT_CYCLES = 2000000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic        flag;
      logic [31:0] arg;
      logic        last;
   } timer_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   periodic_timer_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // timer table mirror
   logic [63:0] now_ticks;
   logic        busy_slot [NSLOT];
   logic [63:0] due_at [NSLOT];
   logic [31:0] reload [NSLOT];
   logic        periodic [NSLOT];
   logic [31:0] payload [NSLOT];

   logic [71:0]   pending_reqs [$];
   timer_result_t expected_results [$];
   int            failures = 0;
   int            fired_seen = 0;
   int            full_seen = 0;
   int            answers_seen = 0;
   int            sent = 0;
   logic          feeding_done = 1'b0;
   logic          hold_off = 1'b0;
   longint        cycles = 0;

   function automatic logic [71:0] pack_req(op_type op, logic [31:0] per, logic rep,
                                            logic [31:0] arg, logic [3:0] sn);
      return {1'b0, sn, arg, rep, per, op};
   endfunction

   function automatic void push_result(kind_type k, int s, logic f, logic [31:0] a);
      timer_result_t r;
      r.kind = k;
      r.slot = s[3:0];
      r.flag = f;
      r.arg = a;
      r.last = 1'b0;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_timer(logic [71:0] d);
      op_type      op;
      logic [31:0] per;
      logic        rep;
      logic [31:0] arg;
      logic [3:0]  sn;
      logic        done [NSLOT];
      int          best;
      int          n;
      int          free_idx;
      logic        f;
      timer_result_t r;
      op = op_type'(d[1:0]);
      per = d[33:2];
      rep = d[34];
      arg = d[66:35];
      sn = d[70:67];
      n = 0;
      case (op)
         OP_TICK: begin
            foreach (done[i]) done[i] = 1'b0;
            now_ticks = now_ticks + 64'd1;
            while (n < ResultLimit) begin
               best = -1;
               for (int i = 0; i < NSLOT; i++) begin
                  if (busy_slot[i] && !done[i] && due_at[i] <= now_ticks)
                     if (best < 0 || due_at[i] < due_at[best]) best = i;
               end
               if (best < 0) break;
               done[best] = 1'b1;
               push_result(RK_FIRED, best, 1'b0, payload[best]);
               n++;
               if (periodic[best] && reload[best] != 0)
                  due_at[best] = due_at[best] + {32'd0, reload[best]};
               else
                  busy_slot[best] = 1'b0;
            end
         end
         OP_START: begin
            free_idx = -1;
            for (int i = 0; i < NSLOT; i++)
               if (free_idx < 0 && !busy_slot[i]) free_idx = i;
            if (free_idx < 0) begin
               push_result(RK_FULL, 0, 1'b0, '0);
            end else begin
               busy_slot[free_idx] = 1'b1;
               due_at[free_idx] = now_ticks + {32'd0, per};
               reload[free_idx] = per;
               periodic[free_idx] = rep;
               payload[free_idx] = arg;
               push_result(RK_STARTED, free_idx, 1'b0, '0);
            end
            n = 1;
         end
         default: begin
            f = busy_slot[sn];
            if (op == OP_STOP) busy_slot[sn] = 1'b0;
            push_result(RK_ANSWER, sn, f, '0);
            n = 1;
         end
      endcase
      if (n > 0) begin
         r = expected_results.pop_back();
         r.last = 1'b1;
         expected_results.push_back(r);
      end
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // request driver
   int req_gap = 0;
   logic req_accepted = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            // handshake already sampled at posedge; refill here
         end
         if (!req_tvalid || req_accepted) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tdata <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_accepted <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         predict_timer(req_tdata);
         req_accepted <= 1'b1;
         sent++;
      end
   end

   // result monitor
   always @(posedge clock) begin
      timer_result_t got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[1:0];
         got.slot = rsp_tdata[5:2];
         got.flag = rsp_tdata[6];
         got.arg = rsp_tdata[38:7];
         got.last = rsp_tlast;
         if (expected_results.size() == 0) begin
            $error("unexpected transfer kind=%0d slot=%0d", got.kind, got.slot);
            failures++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got.kind != exp_r.kind) begin
               $error("result_kind expected %0d got %0d", exp_r.kind, got.kind);
               failures++;
            end
            if (got.slot != exp_r.slot) begin
               $error("result_slot expected %0d got %0d", exp_r.slot, got.slot);
               failures++;
            end
            if (got.flag != exp_r.flag) begin
               $error("answer_flag expected %0d got %0d", exp_r.flag, got.flag);
               failures++;
            end
            if (got.arg != exp_r.arg) begin
               $error("fired_argument expected %h got %h", exp_r.arg, got.arg);
               failures++;
            end
            if (got.last != exp_r.last) begin
               $error("last_result expected %0d got %0d", exp_r.last, got.last);
               failures++;
            end
            case (kind_type'(exp_r.kind))
               RK_FIRED: fired_seen++;
               RK_FULL: full_seen++;
               RK_ANSWER: answers_seen++;
               default: ;
            endcase
         end
      end
   end

   // receiver stalls, with one long hold-off
   int rsp_gap = 0;
   int hold_count = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
         if (hold_count >= 600) hold_off <= 1'b0;
         hold_count <= hold_count + 1;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap <= gap_len();
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_period();
      if ($urandom_range(0, 19) == 0) return rand_word();
      return $urandom_range(0, 6);
   endfunction

   task automatic add_req(logic [71:0] d);
      pending_reqs.push_back(d);
   endtask

   initial begin
      op_type op;
      now_ticks = '0;
      foreach (busy_slot[i]) busy_slot[i] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty queries, quiet tick, fill table, full, stops, extremes
      add_req(pack_req(OP_QUERY, '0, 1'b0, '0, 4'd15));
      add_req(pack_req(OP_STOP, '0, 1'b0, '0, 4'd0));
      add_req(pack_req(OP_TICK, '0, 1'b0, '0, 4'd0));
      add_req(pack_req(OP_START, 32'd0, 1'b1, 32'h7FFF_FFFF, 4'd0));
      add_req(pack_req(OP_START, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 4'd0));
      add_req(pack_req(OP_START, 32'd1, 1'b1, 32'hFFFF_FFFF, 4'd0));
      add_req(pack_req(OP_START, 32'd2, 1'b0, 32'h0000_0001, 4'd0));
      for (int i = 0; i < 12; i++)
         add_req(pack_req(OP_START, 32'd3, i[0], $urandom(), 4'd0));
      add_req(pack_req(OP_START, 32'd5, 1'b0, 32'hFFFF_FFFF, 4'hF));
      add_req(pack_req(OP_QUERY, '0, 1'b0, '0, 4'd3));
      add_req(pack_req(OP_STOP, '0, 1'b0, '0, 4'd1));
      add_req(pack_req(OP_STOP, '0, 1'b0, '0, 4'd1));
      // the sender keeps offering while the receiver holds off
      hold_off = 1'b1;
      for (int i = 0; i < 4; i++)
         add_req(pack_req(OP_TICK, '0, 1'b0, '0, 4'd0));

      // random traffic: mostly start/tick with short periods
      for (int i = 0; i < 460; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: op = OP_START;
            3, 4, 5, 6: op = OP_TICK;
            7: op = OP_STOP;
            default: op = OP_QUERY;
         endcase
         add_req(pack_req(op, rand_period(), $urandom_range(0, 1), rand_word(),
                          $urandom_range(0, 15)));
      end
      for (int i = 0; i < 10; i++)
         add_req(pack_req(OP_TICK, '0, 1'b0, '0, 4'd0));

      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (400) @(posedge clock);
      $display("Sent %0d requests; checked %0d firings, %0d full, %0d answers.",
               sent, fired_seen, full_seen, answers_seen);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
